@@ sv/vpra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpra_pkg: shared types and constants of the packet ring allocator
// Sizes, request and status codes, the packet record layout and slot helpers.
// ----------------------------------------------------------------------------
package vpra_pkg;

	localparam int MAX_MEM_BYTES = 4096;
	localparam int HEADER_BYTES  = 8;
	localparam int MAX_PACKETS   = 64;

	localparam int FIELD_W = 12;                             // offset/length fields
	localparam int CFG_W   = 13;                             // mem_bytes register
	localparam int OFS_W   = $clog2(MAX_MEM_BYTES) + 1;      // stored byte offsets
	localparam int CW      = ((OFS_W > CFG_W) ? OFS_W : CFG_W) + 1; // compare width
	localparam int SLOT_W  = $clog2(MAX_PACKETS);
	localparam int CNT_W   = $clog2(MAX_PACKETS + 1);

	localparam logic [CFG_W-1:0] MEM_BYTES_RST = CFG_W'(4096);

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic [OFS_W-1:0]   start;
		logic [FIELD_W-1:0] len;
	} rec_t;

	typedef struct packed {
		status_t          status;
		logic             placed;
		logic [OFS_W-1:0] offset;
		logic [OFS_W-1:0] tail_end;
	} place_t;

	function automatic slot_t next_slot(input slot_t s);
		return (s == SLOT_W'(MAX_PACKETS - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

endpackage

@@ sv/variable_packet_ring_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_packet_ring_allocator: byte offset allocator for a packet ring
// Hands out offsets for variable-length packets held in FIFO order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries a request: req_type 0 allocates
//   a packet of pkt_len payload bytes, req_type 1 frees the oldest packet.
//   Output channel (out_valid/out_stall) returns one result per request:
//   status, alloc_offset, queue_empty and the oldest packet's offset/length.
//   A request is captured in an input register, then one pass of
//   compare/add logic on the cached head and tail records updates the state
//   and loads the result register. One request per clock is taken sustained
//   while out_stall is low; the record store is read one entry ahead so a
//   run of frees never waits on its registered read port.
//   When the receiver holds out_stall, the result register holds, the input
//   register fills and then in_stall rises; nothing is dropped.
//   cfg_we/cfg_wdata write mem_bytes; write it only while idle.
//   Reset empties the queue and sets mem_bytes to 4096. The record store is
//   not cleared: an entry is read only after it was written.
// ----------------------------------------------------------------------------
module variable_packet_ring_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vpra_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [vpra_pkg::FIELD_W-1:0]  pkt_len,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [vpra_pkg::FIELD_W-1:0]  alloc_offset,
	output logic                          queue_empty,
	output logic [vpra_pkg::FIELD_W-1:0]  head_offset,
	output logic [vpra_pkg::FIELD_W-1:0]  head_len
);
	import vpra_pkg::*;

	// configuration
	logic [CFG_W-1:0] mem_bytes_q;

	// input stage
	logic               valid_s1;
	logic               req_type_s1;
	logic [FIELD_W-1:0] pkt_len_s1;

	// result stage
	logic               valid_s2;
	status_t            status_s2;
	logic [FIELD_W-1:0] alloc_offset_s2;
	logic               queue_empty_s2;
	logic [FIELD_W-1:0] head_offset_s2;
	logic [FIELD_W-1:0] head_len_s2;

	// queue state: cached head record and end of the newest packet
	logic [CNT_W-1:0] cnt_q;
	slot_t            oldest_q;
	slot_t            newest_q;
	rec_t             head_q;
	logic [OFS_W-1:0] tail_end_q;

	logic             s2_open;
	logic             exec;
	logic             free_ok;
	place_t           pl;
	rec_t             next_rec;
	rec_t             new_rec;
	logic [CNT_W-1:0] cnt_n;
	slot_t            oldest_n;
	slot_t            newest_n;
	rec_t             head_n;
	logic [OFS_W-1:0] tail_end_n;

	// the result register frees up when empty or when its transfer completes
	assign s2_open  = !valid_s2 || !out_stall;
	assign exec     = valid_s1 && s2_open;
	assign in_stall = valid_s1 && !s2_open;

	vpra_place u_place (
		.req_type   (req_type_s1),
		.pkt_len    (pkt_len_s1),
		.mem_bytes  (mem_bytes_q),
		.cnt        (cnt_q),
		.head_start (head_q.start),
		.tail_end   (tail_end_q),
		.res        (pl)
	);

	assign new_rec.start = pl.offset;
	assign new_rec.len   = pkt_len_s1;

	// next state of the queue for the request in the input register
	always_comb begin
		free_ok    = (req_type_s1 == REQ_FREE) && (cnt_q != '0);
		cnt_n      = cnt_q;
		oldest_n   = oldest_q;
		newest_n   = newest_q;
		head_n     = head_q;
		tail_end_n = tail_end_q;
		if (exec) begin
			if (pl.placed) begin
				cnt_n      = cnt_q + CNT_W'(1);
				tail_end_n = pl.tail_end;
				if (cnt_q == '0) begin
					// first packet restarts both slots at zero
					oldest_n = '0;
					newest_n = '0;
					head_n   = new_rec;
				end else begin
					newest_n = next_slot(newest_q);
				end
			end else if (free_ok) begin
				cnt_n = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					oldest_n = '0;
					newest_n = '0;
				end else begin
					// promote the prefetched second-oldest record
					oldest_n = next_slot(oldest_q);
					head_n   = next_rec;
				end
			end
		end
	end

	// keep the record after the oldest prefetched in the store's read register
	vpra_rec_mem u_rec_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (exec && pl.placed),
		.wr_addr (newest_n),
		.wr_data (new_rec),
		.rd_addr (next_slot(oldest_n)),
		.rd_data (next_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_bytes_q <= MEM_BYTES_RST;
		end else if (cfg_we) begin
			mem_bytes_q <= cfg_wdata;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			oldest_q <= '0;
			newest_q <= '0;
		end else begin
			cnt_q    <= cnt_n;
			oldest_q <= oldest_n;
			newest_q <= newest_n;
		end
	end

	always_ff @(posedge clk) begin
		head_q     <= head_n;
		tail_end_q <= tail_end_n;
	end

	// input register: load whenever it is not held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1 <= req_type;
			pkt_len_s1  <= pkt_len;
		end
	end

	// result register: load on execute, drop valid once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (exec) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_s2       <= pl.status;
			alloc_offset_s2 <= FIELD_W'(pl.offset);
			queue_empty_s2  <= (cnt_n == '0);
			head_offset_s2  <= (cnt_n == '0) ? '0 : FIELD_W'(head_n.start);
			head_len_s2     <= (cnt_n == '0) ? '0 : head_n.len;
		end
	end

	assign out_valid    = valid_s2;
	assign status       = status_s2;
	assign alloc_offset = alloc_offset_s2;
	assign queue_empty  = queue_empty_s2;
	assign head_offset  = head_offset_s2;
	assign head_len     = head_len_s2;

endmodule

@@ sv/vpra_rec_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpra_rec_mem: packet record store
// One write and one registered read per cycle, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module vpra_rec_mem (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  vpra_pkg::slot_t      wr_addr,
	input  vpra_pkg::rec_t       wr_data,
	input  vpra_pkg::slot_t      rd_addr,
	output vpra_pkg::rec_t       rd_data
);
	import vpra_pkg::*;

	rec_t mem [MAX_PACKETS];
	rec_t rd_q;
	rec_t wd_q;
	logic byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
		wd_q <= wr_data;
	end

	// forward a record written in the same cycle it is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? wd_q : rd_q;

endmodule

@@ sv/vpra_place.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpra_place: placement decision
// Checks fifo room and ring space for one request and picks the offset.
// ----------------------------------------------------------------------------
module vpra_place (
	input  logic                          req_type,
	input  logic [vpra_pkg::FIELD_W-1:0]  pkt_len,
	input  logic [vpra_pkg::CFG_W-1:0]    mem_bytes,
	input  logic [vpra_pkg::CNT_W-1:0]    cnt,
	input  logic [vpra_pkg::OFS_W-1:0]    head_start,
	input  logic [vpra_pkg::OFS_W-1:0]    tail_end,
	output vpra_pkg::place_t              res
);
	import vpra_pkg::*;

	logic [CW-1:0] foot;
	logic [CW-1:0] mem_cap;
	logic [CW-1:0] mem_use;
	logic [CW-1:0] te;
	logic [CW-1:0] hb;
	logic [CW-1:0] te_plus;
	logic [CW-1:0] ofs;

	always_comb begin
		foot    = (CW'(HEADER_BYTES) + CW'(pkt_len) + CW'(3)) & ~CW'(3);
		mem_cap = (CW'(mem_bytes) > CW'(MAX_MEM_BYTES)) ? CW'(MAX_MEM_BYTES)
		                                                 : CW'(mem_bytes);
		mem_use = mem_cap & ~CW'(3);
		te      = CW'(tail_end);
		hb      = CW'(head_start);
		te_plus = te + foot;

		res.status = ST_OK;
		res.placed = 1'b0;
		ofs        = '0;

		if (req_type == REQ_FREE) begin
			if (cnt == '0) begin
				res.status = ST_EMPTY;
			end
		end else if (cnt == CNT_W'(MAX_PACKETS)) begin
			res.status = ST_FULL;
		end else if (foot > mem_use) begin
			res.status = ST_NO_SPACE;
		end else if (cnt == '0) begin
			res.placed = 1'b1;
		end else if (te <= hb) begin
			// free space is the gap between tail and head
			if (te_plus <= hb) begin
				res.placed = 1'b1;
				ofs        = te;
			end else begin
				res.status = ST_NO_SPACE;
			end
		end else if (foot <= hb) begin
			res.placed = 1'b1;
		end else if (te_plus <= mem_use) begin
			res.placed = 1'b1;
			ofs        = te;
		end else begin
			res.status = ST_NO_SPACE;
		end

		res.offset   = OFS_W'(ofs);
		res.tail_end = OFS_W'(ofs + foot);
	end

endmodule
